// ===== sv/float_hash_mod_mersenne31_unit_defines.svh =====
// Assertion macros for the float hash unit.
// Included by the top level; the macros compile to nothing under SYNTHESIS.
`ifndef FLOAT_HASH_MOD_MERSENNE31_UNIT_DEFINES_SVH
`define FLOAT_HASH_MOD_MERSENNE31_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define FHM31_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fhm31 same-cycle check failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define FHM31_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fhm31 next-cycle check failed");
`else
`define FHM31_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FHM31_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/fhm31_pkg.sv =====
// Constants and helper functions for the float hash unit.
// No dependencies; used by the channel interfaces and the top level.
package fhm31_pkg;

	localparam int VALUE_W   = 64;
	localparam int HASH_W    = 32;
	localparam int HASH_BITS = 31;
	localparam int EXP_W     = 11;
	localparam int FRAC_W    = 52;
	localparam int SIG_W     = FRAC_W + 1;
	localparam int EXP_BIAS  = 1075;
	// Offset that makes (field + ROT_OFS) mod 31 equal (field - 1075) mod 31.
	localparam int ROT_OFS   = HASH_BITS * 35 - EXP_BIAS;

	localparam logic [HASH_BITS-1:0] HASH_MOD = '1;
	localparam logic [HASH_W-1:0]    HASH_INF = 32'd314159;
	localparam logic [EXP_W-1:0]     EXP_MAX  = '1;

	typedef logic [HASH_BITS-1:0] resid_t;
	typedef logic [4:0]           rot_t;

	// Reduce a 53-bit significand modulo 2^31-1.
	function automatic resid_t fold_mod(input logic [SIG_W-1:0] s);
		logic [HASH_BITS:0]   r1;
		logic [HASH_BITS-1:0] r2;
		r1 = {1'b0, s[HASH_BITS-1:0]} + {10'b0, s[SIG_W-1:HASH_BITS]};
		r2 = r1[HASH_BITS-1:0] + {30'b0, r1[HASH_BITS]};
		return (r2 == HASH_MOD) ? '0 : r2;
	endfunction

	// Reduce a 12-bit value below 3104 modulo 31 by folding base-32 digits.
	function automatic rot_t mod31(input logic [11:0] x);
		logic [6:0] y;
		logic [5:0] z;
		y = {2'b0, x[4:0]} + x[11:5];
		z = {1'b0, y[4:0]} + {4'b0, y[6:5]};
		return (z >= 6'd31) ? 5'(z - 6'd31) : z[4:0];
	endfunction

	// Rotate a residue left by k within 31 bits.
	function automatic resid_t rotate31(input resid_t r, input rot_t k);
		logic [2*HASH_BITS-1:0] d;
		d = {r, r} << k;
		return d[2*HASH_BITS-1:HASH_BITS];
	endfunction

endpackage

// ===== sv/fhm31_if.sv =====
// Valid/ready channel interfaces for the float hash unit.
// Depends on fhm31_pkg for the payload widths.
interface fhm31_value_if import fhm31_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value_bits;

	modport source (output valid, output value_bits, input ready);
	modport sink (input valid, input value_bits, output ready);
endinterface

interface fhm31_hash_if import fhm31_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [HASH_W-1:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

// ===== sv/float_hash_mod_mersenne31_unit.sv =====
// Top level of the float hash unit: input register, hash logic, result register.
// Depends on fhm31_pkg, the channel interfaces in fhm31_if.sv and the assertion macros.
`include "float_hash_mod_mersenne31_unit_defines.svh"

// Hashes the raw bit pattern of an IEEE 754 double to a signed 32-bit value:
// the magnitude modulo 2^31-1 carrying the input's sign. Infinity gives
// +/-314159, NaN and both zeros give 0, subnormals are exact. The unit is a
// two-register pipeline: an item lands in the input register, the hash is
// formed by one pass of logic (significand fold, exponent mod 31, 31-bit
// rotate, negate) and lands in the result register. Throughput is one item
// per cycle while results are taken; an accepted item moves from the input
// register to the result register, where it is presented, once that register
// can advance. Either register advances whenever the one after it is empty or
// is being drained, so a stalled consumer only blocks once both are full.
// The unit holds no state beyond the pipeline; reset just empties it.
module float_hash_mod_mersenne31_unit import fhm31_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fhm31_value_if.sink   value_ch,
	fhm31_hash_if.source  hash_ch
);

	// Input register
	logic               valid_s1;
	logic [VALUE_W-1:0] bits_s1;
	// Result register
	logic                     valid_s2;
	logic signed [HASH_W-1:0] hash_s2;

	logic adv_s2;
	logic adv_s1;

	// Decoded fields of the held item
	logic             neg;
	logic [EXP_W-1:0] efield;
	logic [FRAC_W-1:0] frac;
	logic             is_special;
	logic             is_zero;
	logic [EXP_W-1:0] eff_exp;
	logic [SIG_W-1:0] sig;
	rot_t             rot;
	resid_t           resid;
	logic [HASH_W-1:0] mag;
	logic signed [HASH_W-1:0] hash_next;

	// Advance the result register when it is empty or being taken.
	assign adv_s2 = !valid_s2 || hash_ch.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign value_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= value_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && value_ch.valid) begin
			bits_s1 <= value_ch.value_bits;
		end
	end

	// Split the double into sign, exponent field and fraction.
	assign neg    = bits_s1[VALUE_W-1];
	assign efield = bits_s1[VALUE_W-2 -: EXP_W];
	assign frac   = bits_s1[FRAC_W-1:0];

	assign is_special = (efield == EXP_MAX);
	assign is_zero    = (efield == '0) && (frac == '0);

	// Subnormals share the exponent of the smallest normal, without the hidden one.
	assign eff_exp = (efield == '0) ? EXP_W'(1) : efield;
	assign sig     = {(efield != '0), frac};

	// 2^p acts on a residue as a rotation by p mod 31, negative p wrapping.
	assign rot   = mod31(12'({1'b0, eff_exp}) + 12'(ROT_OFS));
	assign resid = rotate31(fold_mod(sig), rot);

	always_comb begin
		if (is_special) begin
			mag = (frac == '0) ? HASH_INF : '0;
		end else if (is_zero) begin
			mag = '0;
		end else begin
			mag = {1'b0, resid};
		end
		hash_next = neg ? signed'(HASH_W'(0) - mag) : signed'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			hash_s2 <= hash_next;
		end
	end

	assign hash_ch.valid      = valid_s2;
	assign hash_ch.hash_value = hash_s2;

	// An infinity moving into the result register must come out as +/-314159.
	`FHM31_ASSERT_NEXT(a_inf_hash, clk, arst_n, adv_s2 && valid_s1 && is_special && (frac == '0), (hash_s2 == signed'(HASH_INF)) || (hash_s2 == -signed'(HASH_INF)))
	// NaN and zero inputs must hash to zero.
	`FHM31_ASSERT_NEXT(a_zero_hash, clk, arst_n, adv_s2 && valid_s1 && (is_zero || (is_special && (frac != '0))), hash_s2 == '0)
	// A presented result never reaches the modulus or the most negative code.
	`FHM31_ASSERT_IMPL(a_hash_range, clk, arst_n, valid_s2, (hash_s2 != 32'sh7FFFFFFF) && (hash_s2 != 32'sh80000000) && (hash_s2 != 32'sh80000001))
	// A full pipeline facing a stalled consumer must refuse new items.
	`FHM31_ASSERT_IMPL(a_backpressure, clk, arst_n, valid_s1 && valid_s2 && !hash_ch.ready, !value_ch.ready)

endmodule
